>>> rtl/core/grace_period_reclaim_queue_core_assert.svh
// ----------------------------------------------------------------------------
// grace_period_reclaim_queue_core_assert.svh
// Assertion macros for the reclaim queue core; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GRACE_PERIOD_RECLAIM_QUEUE_CORE_ASSERT_SVH
`define GRACE_PERIOD_RECLAIM_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property at every edge outside reset.
`define GPRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define GPRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GPRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define GPRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/gprq_pkg.sv
// ----------------------------------------------------------------------------
// gprq_pkg
// Shared types and constants of the grace period reclaim queue.
// ----------------------------------------------------------------------------
package gprq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int MAX_OUT   = 32;
    localparam int NFREE_W   = $clog2(MAX_OUT + 1);

    // Input kind codes
    localparam logic [1:0] KIND_DEFER   = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_CHECK   = 2'd2;
    localparam logic [1:0] KIND_FORCE   = 2'd3;

    // Classified command handed from front to back
    typedef enum logic [2:0] {
        OP_DEFER,
        OP_ADVANCE,
        OP_HOLD,
        OP_CHECK,
        OP_FORCE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] handle;
        logic [19:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic        reclaimed;
        logic [15:0] freed_handle;
        logic [19:0] freed_bytes;
        logic        last;
        logic        rejected;
        logic [5:0]  pending_count;
        logic [25:0] pending_bytes;
        logic [31:0] current_period;
        logic [31:0] completed_period;
        logic [31:0] total_freed;
    } t_res;

    typedef struct packed {
        logic [15:0] handle;
        logic [19:0] bytes;
        logic [31:0] period;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EV
    } t_back_state;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

endpackage

>>> rtl/core/gprq_fifo.sv
// ----------------------------------------------------------------------------
// gprq_fifo
// Two-entry register queue; output is taken straight from a register.
// ----------------------------------------------------------------------------
module gprq_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         n_wp;
    logic         n_rp;
    logic [1:0]   n_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/core/gprq_front.sv
// ----------------------------------------------------------------------------
// gprq_front
// Accept input items, classify them into commands and queue them.
// ----------------------------------------------------------------------------
module gprq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_node_handle,
    input  logic [19:0]        i_footprint,
    input  logic               i_readers_active,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop,
    output gprq_pkg::t_cmd     o_cmd
);
    import gprq_pkg::*;

    t_cmd             cmd_in;
    logic [CMD_W-1:0] cmd_q;
    logic             cmd_empty;

    // A check with readers active resolves here to a plain status command.
    always_comb begin
        cmd_in.handle = i_node_handle;
        cmd_in.bytes  = i_footprint;
        case (i_kind)
            KIND_DEFER:   cmd_in.op = OP_DEFER;
            KIND_ADVANCE: cmd_in.op = OP_ADVANCE;
            KIND_CHECK:   cmd_in.op = i_readers_active ? OP_HOLD : OP_CHECK;
            KIND_FORCE:   cmd_in.op = OP_FORCE;
            default:      cmd_in.op = OP_HOLD;
        endcase
    end

    gprq_fifo #(
        .W (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_q),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;
    assign o_cmd       = t_cmd'(cmd_q);

endmodule

>>> rtl/core/gprq_back.sv
// ----------------------------------------------------------------------------
// gprq_back
// Execute commands: entry storage, period counters and the reclaim sequencer.
// ----------------------------------------------------------------------------
`include "grace_period_reclaim_queue_core_assert.svh"

module gprq_back #(
    parameter int DEPTH = gprq_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  gprq_pkg::t_cmd i_cmd,
    output logic           o_res_push,
    output gprq_pkg::t_res o_res,
    input  logic           i_res_full
);
    import gprq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry               r_mem [DEPTH];
    t_entry               r_rdata;
    t_res                 r_prev;
    t_res                 n_prev;
    t_back_state          r_state;
    t_back_state          n_state;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     n_head;
    logic [IDX_W-1:0]     r_tail;
    logic [IDX_W-1:0]     n_tail;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [25:0]          r_bytes;
    logic [25:0]          n_bytes;
    logic [31:0]          r_now;
    logic [31:0]          n_now;
    logic [31:0]          r_done;
    logic [31:0]          n_done;
    logic [31:0]          r_total;
    logic [31:0]          n_total;
    logic [NFREE_W-1:0]   r_nfree;
    logic [NFREE_W-1:0]   n_nfree;
    logic                 r_have_prev;
    logic                 n_have_prev;
    logic                 q_full;
    logic                 start_rcl;
    logic                 eligible;
    logic                 mem_we;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
        next_idx = (x == IDX_W'(DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic t_res make_res(
        input logic             rec,
        input logic [15:0]      h,
        input logic [19:0]      b,
        input logic             lst,
        input logic             rej,
        input logic [CNT_W-1:0] cnt,
        input logic [25:0]      wb,
        input logic [31:0]      now,
        input logic [31:0]      done,
        input logic [31:0]      tot
    );
        t_res r;
        r.reclaimed        = rec;
        r.freed_handle     = h;
        r.freed_bytes      = b;
        r.last             = lst;
        r.rejected         = rej;
        r.pending_count    = (32'(cnt) > 32'd63) ? 6'd63 : 6'(cnt);
        r.pending_bytes    = wb;
        r.current_period   = now;
        r.completed_period = done;
        r.total_freed      = tot;
        return r;
    endfunction

    assign q_full   = (r_count == CNT_W'(DEPTH));
    assign eligible = (r_count != '0) && (r_rdata.period <= r_done)
                      && (r_nfree < NFREE_W'(MAX_OUT));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_now       = r_now;
        n_done      = r_done;
        n_total     = r_total;
        n_nfree     = r_nfree;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = r_prev;
        start_rcl   = 1'b0;
        mem_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_DEFER: begin
                            if (!q_full) begin
                                mem_we  = 1'b1;
                                n_tail  = next_idx(r_tail);
                                n_count = r_count + 1'b1;
                                n_bytes = r_bytes + 26'(i_cmd.bytes);
                            end
                        end
                        OP_ADVANCE: begin
                            if (r_now != '1) begin
                                n_now = r_now + 32'd1;
                            end
                        end
                        OP_CHECK: begin
                            if (r_done < r_now) begin
                                n_done    = r_now;
                                start_rcl = 1'b1;
                            end
                        end
                        OP_FORCE: begin
                            n_done    = r_now;
                            start_rcl = 1'b1;
                        end
                        default: ;
                    endcase
                    if (start_rcl) begin
                        n_state     = S_RD;
                        n_nfree     = '0;
                        n_have_prev = 1'b0;
                    end else begin
                        o_res_push = 1'b1;
                        o_res = make_res(1'b0, 16'd0, 20'd0, 1'b1,
                                         (i_cmd.op == OP_DEFER) && q_full,
                                         n_count, n_bytes, n_now, n_done, n_total);
                    end
                end
            end
            S_RD: begin
                // Head entry is being read out of the array.
                n_state = S_EV;
            end
            S_EV: begin
                if (eligible) begin
                    if (!(r_have_prev && i_res_full)) begin
                        // Release the held result; this pop is not the last.
                        o_res_push  = r_have_prev;
                        n_head      = next_idx(r_head);
                        n_count     = r_count - 1'b1;
                        n_bytes     = r_bytes - 26'(r_rdata.bytes);
                        n_total     = r_total + 32'd1;
                        n_nfree     = r_nfree + 1'b1;
                        n_prev      = make_res(1'b1, r_rdata.handle, r_rdata.bytes,
                                               1'b0, 1'b0, n_count, n_bytes,
                                               r_now, r_done, n_total);
                        n_have_prev = 1'b1;
                        n_state     = S_RD;
                    end
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_have_prev) begin
                        o_res      = r_prev;
                        o_res.last = 1'b1;
                    end else begin
                        o_res = make_res(1'b0, 16'd0, 20'd0, 1'b1, 1'b0, r_count,
                                         r_bytes, r_now, r_done, r_total);
                    end
                    n_have_prev = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_now       <= '0;
            r_done      <= '0;
            r_total     <= '0;
            r_nfree     <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_now       <= n_now;
            r_done      <= n_done;
            r_total     <= n_total;
            r_nfree     <= n_nfree;
            r_have_prev <= n_have_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
    end

    // Entry array: one write port at the tail, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= '{handle: i_cmd.handle, bytes: i_cmd.bytes, period: r_now};
        end
        r_rdata <= r_mem[r_head];
    end

    `GPRQ_ASSERT(a_count_le_depth, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `GPRQ_ASSERT(a_done_le_now, i_clk, i_rst_n, r_done <= r_now, "completed period ahead of current")
    `GPRQ_ASSERT(a_push_has_room, i_clk, i_rst_n, o_res_push |-> !i_res_full, "result pushed into full queue")
    `GPRQ_ASSERT(a_nfree_cap, i_clk, i_rst_n, r_nfree <= NFREE_W'(MAX_OUT), "too many frees for one item")
    `GPRQ_ASSERT_NEXT(a_rd_then_ev, i_clk, i_rst_n, r_state == S_RD, r_state == S_EV, "read state not followed by evaluate")

endmodule

>>> rtl/core/grace_period_reclaim_queue_core.sv
// ----------------------------------------------------------------------------
// grace_period_reclaim_queue_core
// Deferred node reclamation queue ordered by grace period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive kind, node_handle, footprint and readers_active with
//   push high; the item transfers on a rising edge where full is low.
//   Result channel: while empty is low the oldest result sits on the o_ ports;
//   it transfers on a rising edge with pop high. Every item yields one or more
//   results, the final one with last set.
//   Path (executor idle): a status result is registered in the command queue,
//   then in the result queue. A reclaim steps through the read and evaluate
//   states for each entry, set by the registered read port of the entry array.
//   Throughput: defer, advance and a blocked check keep the executor idle, so
//   one item per cycle is sustained while the result queue has room. A reclaim
//   freeing N nodes (N <= 32) holds the executor until its last result.
//   Stall: when the receiver holds pop low the result queue fills, the executor
//   holds, then the command queue fills and full rises. Nothing is dropped.
//   Reset: synchronous, active low; clears list, periods, freed count and both queues.
// ----------------------------------------------------------------------------
module grace_period_reclaim_queue_core #(
    parameter int DEPTH = gprq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_node_handle,
    input  logic [19:0] i_footprint,
    input  logic        i_readers_active,
    output logic        empty,
    input  logic        pop,
    output logic        o_reclaimed,
    output logic [15:0] o_freed_handle,
    output logic [19:0] o_freed_bytes,
    output logic        o_last,
    output logic        o_rejected,
    output logic [5:0]  o_pending_count,
    output logic [25:0] o_pending_bytes,
    output logic [31:0] o_current_period,
    output logic [31:0] o_completed_period,
    output logic [31:0] o_total_freed
);
    import gprq_pkg::*;

    t_cmd             cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    t_res             res_in;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_q;
    t_res             res_out;

    // Front: classify and queue incoming items
    gprq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_kind           (i_kind),
        .i_node_handle    (i_node_handle),
        .i_footprint      (i_footprint),
        .i_readers_active (i_readers_active),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop),
        .o_cmd            (cmd)
    );

    // Back: execute commands and sequence reclamation
    gprq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // Result queue: parts the executor from a stalling receiver
    gprq_fifo #(
        .W (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out            = t_res'(res_q);
    assign o_reclaimed        = res_out.reclaimed;
    assign o_freed_handle     = res_out.freed_handle;
    assign o_freed_bytes      = res_out.freed_bytes;
    assign o_last             = res_out.last;
    assign o_rejected         = res_out.rejected;
    assign o_pending_count    = res_out.pending_count;
    assign o_pending_bytes    = res_out.pending_bytes;
    assign o_current_period   = res_out.current_period;
    assign o_completed_period = res_out.completed_period;
    assign o_total_freed      = res_out.total_freed;

endmodule
